/* rtl/tma_pkg.sv */
// tma_pkg: shared types and constants for the transform matrix accumulator.
// Used by tma_ctrl, tma_datapath and transform_matrix_accumulator_core.
// No dependencies.
package tma_pkg;

	localparam int WORD_W = 32;
	localparam int DIM    = 4;
	localparam int CELLS  = DIM * DIM;
	localparam int IDX_W  = 2;
	localparam int CELL_W = 2 * IDX_W;

	localparam logic [1:0] MODE_LOAD      = 2'd0;
	localparam logic [1:0] MODE_IDENTITY  = 2'd1;
	localparam logic [1:0] MODE_TRANSPOSE = 2'd2;

	localparam logic [CELL_W-1:0] LAST_CELL = 4'd15;
	localparam logic [IDX_W-1:0]  LAST_K    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		KIND_MAC,
		KIND_IDENT,
		KIND_COPY
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [CELL_W-1:0] pos;
		logic [IDX_W-1:0]  k;
		logic              first;
		logic              lastk;
		logic              op_we;
		logic [CELL_W-1:0] op_waddr;
	} cmd_t;

	typedef struct packed {
		logic wr_last;
	} status_t;

endpackage

/* rtl/tma_ctrl.sv */
// tma_ctrl: controller FSM; accepts words, counts operand loads and sequences
// the element/term sweep for multiply, identity and transpose.
// Depends on tma_pkg.
module tma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  tma_pkg::status_t     status,
	output logic                 busy,
	output tma_pkg::cmd_t        cmd
);

	tma_pkg::state_t                  state_q, state_d;
	tma_pkg::kind_t                   kind_q;
	logic [tma_pkg::CELL_W-1:0]       load_cnt_q;
	logic [tma_pkg::CELL_W-1:0]       cell_q;
	logic [tma_pkg::IDX_W-1:0]        k_q;
	logic                             lastk;
	logic                             accept;

	assign accept = start && (state_q == tma_pkg::ST_IDLE);
	assign lastk  = (kind_q != tma_pkg::KIND_MAC) || (k_q == tma_pkg::LAST_K);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tma_pkg::ST_IDLE: begin
				if (start) begin
					case (mode)
						tma_pkg::MODE_LOAD: begin
							if (load_cnt_q == tma_pkg::LAST_CELL)
								state_d = tma_pkg::ST_RUN;
						end
						tma_pkg::MODE_IDENTITY:  state_d = tma_pkg::ST_RUN;
						tma_pkg::MODE_TRANSPOSE: state_d = tma_pkg::ST_RUN;
						default:                 state_d = tma_pkg::ST_IDLE;
					endcase
				end
			end
			tma_pkg::ST_RUN: begin
				if (lastk && (cell_q == tma_pkg::LAST_CELL))
					state_d = tma_pkg::ST_DRAIN;
			end
			tma_pkg::ST_DRAIN: begin
				if (status.wr_last)
					state_d = tma_pkg::ST_IDLE;
			end
			default: state_d = tma_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q != tma_pkg::ST_IDLE);
		cmd.valid    = (state_q == tma_pkg::ST_RUN);
		cmd.kind     = kind_q;
		cmd.pos      = cell_q;
		cmd.k        = k_q;
		cmd.first    = (k_q == '0);
		cmd.lastk    = lastk;
		cmd.op_we    = accept && (mode == tma_pkg::MODE_LOAD);
		cmd.op_waddr = load_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tma_pkg::ST_IDLE;
			kind_q     <= tma_pkg::KIND_MAC;
			load_cnt_q <= '0;
			cell_q     <= '0;
			k_q        <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cell_q <= '0;
				k_q    <= '0;
				case (mode)
					tma_pkg::MODE_LOAD: begin
						kind_q     <= tma_pkg::KIND_MAC;
						load_cnt_q <= load_cnt_q + 1'b1;
					end
					tma_pkg::MODE_IDENTITY:  kind_q <= tma_pkg::KIND_IDENT;
					tma_pkg::MODE_TRANSPOSE: kind_q <= tma_pkg::KIND_COPY;
					default:                 kind_q <= kind_q;
				endcase
			end else if (state_q == tma_pkg::ST_RUN) begin
				if (lastk) begin
					k_q    <= '0;
					cell_q <= cell_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	a_wr_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		status.wr_last |-> (state_q == tma_pkg::ST_DRAIN))
		else $error("final write outside drain");

	a_load_wrap_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op_we && (load_cnt_q == tma_pkg::LAST_CELL)
		|=> (state_q == tma_pkg::ST_RUN) && (cell_q == '0) && (k_q == '0)
		&& (kind_q == tma_pkg::KIND_MAC))
		else $error("sixteenth load did not start multiply");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op_we |-> !busy && !cmd.valid)
		else $error("operand write while busy");

endmodule

/* rtl/tma_datapath.sv */
// tma_datapath: operand buffer, double-banked matrix store, shared multiplier
// and saturating accumulator, registered result outputs.
// Depends on tma_pkg; driven by tma_ctrl commands.
module tma_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tma_pkg::cmd_t                       cmd,
	input  logic signed [tma_pkg::WORD_W-1:0]   value,
	output tma_pkg::status_t                    status,
	output logic                                strobe,
	output logic signed [tma_pkg::WORD_W-1:0]   element,
	output logic [tma_pkg::IDX_W-1:0]           row,
	output logic [tma_pkg::IDX_W-1:0]           column,
	output logic                                last
);

	localparam int W         = tma_pkg::WORD_W;
	localparam int PROD_W    = 2 * W - FRAC_BITS;
	localparam int ACC_W     = PROD_W + 2;
	localparam int MEM_DEPTH = 2 * tma_pkg::CELLS;
	localparam int ADDR_W    = tma_pkg::CELL_W + 1;
	localparam logic signed [W-1:0] FIX_ONE = W'(1) << FRAC_BITS;
	localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0]            op_mem [tma_pkg::CELLS];
	logic signed [W-1:0]            cur_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]           valid_q;
	logic                           bank_q;

	logic [tma_pkg::CELL_W-1:0]     rd_cell;
	logic [ADDR_W-1:0]              rd_addr;
	logic [ADDR_W-1:0]              wr_addr;

	tma_pkg::cmd_t                  cmd_s1, cmd_s2;
	logic signed [W-1:0]            op_rd_s1, cur_rd_s1;
	logic                           vld_s1;
	logic [tma_pkg::CELL_W-1:0]     rd_cell_s1;
	logic signed [W-1:0]            cur_s1;

	logic signed [2*W-1:0]          prod_s2;
	logic signed [W-1:0]            val_s2;

	logic signed [2*W-1:0]          prod_shift;
	logic signed [PROD_W-1:0]       prod_trunc;
	logic signed [ACC_W-1:0]        acc_q, sum;
	logic signed [W-1:0]            mac_sat, result;
	logic                           wr_en;

	logic                           strobe_q, last_q;
	logic signed [W-1:0]            element_q;
	logic [tma_pkg::IDX_W-1:0]      row_q, column_q;

	// read address: term A[k][j] for multiply, A[j][i] for transpose
	always_comb begin
		case (cmd.kind)
			tma_pkg::KIND_MAC:  rd_cell = {cmd.k, cmd.pos[1:0]};
			tma_pkg::KIND_COPY: rd_cell = {cmd.pos[1:0], cmd.pos[3:2]};
			default:            rd_cell = cmd.pos;
		endcase
	end
	assign rd_addr = {bank_q, rd_cell};
	assign wr_addr = {~bank_q, cmd_s2.pos};

	always_ff @(posedge clk) begin
		if (cmd.op_we)
			op_mem[cmd.op_waddr] <= value;
		op_rd_s1 <= op_mem[{cmd.pos[3:2], cmd.k}];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			cur_mem[wr_addr] <= result;
		cur_rd_s1 <= cur_mem[rd_addr];
	end

	// entries never written read as identity
	always_comb begin
		if (vld_s1)
			cur_s1 = cur_rd_s1;
		else if (rd_cell_s1[3:2] == rd_cell_s1[1:0])
			cur_s1 = FIX_ONE;
		else
			cur_s1 = '0;
	end

	always_ff @(posedge clk) begin
		rd_cell_s1 <= rd_cell;
		prod_s2    <= op_rd_s1 * cur_s1;
		val_s2     <= cur_s1;
	end

	assign prod_shift = prod_s2 >>> FRAC_BITS;
	assign prod_trunc = prod_shift[PROD_W-1:0];
	assign sum        = (cmd_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_trunc);

	always_comb begin
		if (&sum[ACC_W-1:W-1] || ~|sum[ACC_W-1:W-1])
			mac_sat = sum[W-1:0];
		else if (sum[ACC_W-1])
			mac_sat = SAT_MIN;
		else
			mac_sat = SAT_MAX;
	end

	always_comb begin
		case (cmd_s2.kind)
			tma_pkg::KIND_MAC:   result = mac_sat;
			tma_pkg::KIND_IDENT: result = (cmd_s2.pos[3:2] == cmd_s2.pos[1:0]) ? FIX_ONE : '0;
			default:             result = val_s2;
		endcase
	end

	assign wr_en          = cmd_s2.valid && cmd_s2.lastk;
	assign status.wr_last = wr_en && (cmd_s2.pos == tma_pkg::LAST_CELL);

	always_ff @(posedge clk) begin
		if (cmd_s2.valid && (cmd_s2.kind == tma_pkg::KIND_MAC))
			acc_q <= sum;
		element_q <= result;
		row_q     <= cmd_s2.pos[3:2];
		column_q  <= cmd_s2.pos[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1   <= '0;
			cmd_s2   <= '0;
			vld_s1   <= 1'b0;
			valid_q  <= '0;
			bank_q   <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			cmd_s1   <= cmd;
			cmd_s2   <= cmd_s1;
			vld_s1   <= valid_q[rd_addr];
			strobe_q <= wr_en;
			last_q   <= status.wr_last;
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (status.wr_last)
				bank_q <= ~bank_q;
		end
	end

	assign strobe  = strobe_q;
	assign element = element_q;
	assign row     = row_q;
	assign column  = column_q;
	assign last    = last_q;

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		status.wr_last |=> (bank_q != $past(bank_q)))
		else $error("bank did not flip after final write");

	a_mac_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_s2.valid && (cmd_s2.kind == tma_pkg::KIND_MAC) && !cmd_s2.first
		|-> $past(cmd_s2.valid) && ($past(cmd_s2.pos) == cmd_s2.pos))
		else $error("broken multiply-accumulate group");

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

endmodule

/* rtl/transform_matrix_accumulator_core.sv */
// Holds a 4x4 Q(32-FRAC_BITS).FRAC_BITS transform matrix, reset to identity.
// A mode 0 word loads one operand element (row-major); the sixteenth starts
// the product operand*M, M being the held matrix, on one shared 32x32
// multiplier, four terms per element, so busy stays high until the last
// element is written and results come one per element. Identity and
// transpose words keep busy high likewise and give one result per cycle.
// Mode 3 is taken and does nothing. Each result shows on element/row/column/last
// for one cycle with strobe high; the receiver cannot hold it off.
// Depends on tma_pkg, tma_ctrl and tma_datapath.
module transform_matrix_accumulator_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [tma_pkg::WORD_W-1:0]   value,
	output logic                                strobe,
	output logic signed [tma_pkg::WORD_W-1:0]   element,
	output logic [tma_pkg::IDX_W-1:0]           row,
	output logic [tma_pkg::IDX_W-1:0]           column,
	output logic                                last
);

	tma_pkg::cmd_t    cmd;
	tma_pkg::status_t status;

	tma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	tma_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (value),
		.status  (status),
		.strobe  (strobe),
		.element (element),
		.row     (row),
		.column  (column),
		.last    (last)
	);

endmodule

/* dv/tma_product_checker.sv */
`timescale 1ns / 100ps
// tma_product_checker: watches the command and result ports of the transform
// matrix accumulator, predicts each result word and compares them in order.
// Depends on tma_pkg.
module tma_product_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        mode,
	input  logic signed [tma_pkg::WORD_W-1:0] value,
	input  logic                              strobe,
	input  logic signed [tma_pkg::WORD_W-1:0] element,
	input  logic [tma_pkg::IDX_W-1:0]         row,
	input  logic [tma_pkg::IDX_W-1:0]         column,
	input  logic                              last,
	output int                                fail_count,
	output int                                words_due
);
	import tma_pkg::*;

	localparam longint S32_MAX = (longint'(1) <<< 31) - 1;
	localparam longint S32_MIN = -(longint'(1) <<< 31);

	typedef struct packed {
		logic signed [WORD_W-1:0] element;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         column;
		logic                     last;
	} matrix_word_t;

	logic signed [WORD_W-1:0] held [CELLS];
	logic signed [WORD_W-1:0] operand [CELLS];
	logic [CELL_W-1:0]        loads_taken;
	matrix_word_t             matrix_words_q [$];
	int                       fail_tally;

	// one element of operand * held: floor-truncated products, saturated sum
	function automatic logic signed [WORD_W-1:0] product_cell(int i, int j);
		longint acc;
		longint term;
		acc = 0;
		for (int k = 0; k < DIM; k++) begin
			term = longint'(operand[i * DIM + k]) * longint'(held[k * DIM + j]);
			acc += term >>> FRAC_BITS;
		end
		if (acc > S32_MAX)
			return 32'sh7FFF_FFFF;
		if (acc < S32_MIN)
			return 32'sh8000_0000;
		return acc[WORD_W-1:0];
	endfunction

	task automatic load_identity();
		for (int n = 0; n < CELLS; n++)
			held[n] = (n % (DIM + 1) == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
	endtask

	task automatic queue_matrix();
		matrix_word_t w;
		for (int n = 0; n < CELLS; n++) begin
			w.element = held[n];
			w.row     = IDX_W'(n / DIM);
			w.column  = IDX_W'(n % DIM);
			w.last    = (n == CELLS - 1);
			matrix_words_q.push_back(w);
		end
	endtask

	task automatic apply_command(input logic [1:0] m, input logic signed [WORD_W-1:0] v);
		logic signed [WORD_W-1:0] next [CELLS];
		logic signed [WORD_W-1:0] t;
		case (m)
			MODE_LOAD: begin
				operand[loads_taken] = v;
				loads_taken = loads_taken + 1'b1;
				if (loads_taken == '0) begin
					for (int i = 0; i < DIM; i++)
						for (int j = 0; j < DIM; j++)
							next[i * DIM + j] = product_cell(i, j);
					held = next;
					queue_matrix();
				end
			end
			MODE_IDENTITY: begin
				load_identity();
				queue_matrix();
			end
			MODE_TRANSPOSE: begin
				for (int i = 0; i < DIM; i++)
					for (int j = i + 1; j < DIM; j++) begin
						t = held[i * DIM + j];
						held[i * DIM + j] = held[j * DIM + i];
						held[j * DIM + i] = t;
					end
				queue_matrix();
			end
			default: ;
		endcase
	endtask

	task automatic report(input string field, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
			fail_tally++;
		end
	endtask

	task automatic compare_word();
		matrix_word_t w;
		if (matrix_words_q.size() == 0) begin
			$display("%0t: unexpected result word, element %0d row %0d column %0d last %0d",
				$time, element, row, column, last);
			fail_tally++;
		end else begin
			w = matrix_words_q.pop_front();
			report("element", w.element, element);
			report("row", w.row, row);
			report("column", w.column, column);
			report("last", w.last, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_identity();
			for (int n = 0; n < CELLS; n++)
				operand[n] = '0;
			loads_taken = '0;
			matrix_words_q.delete();
			fail_tally = 0;
			fail_count <= 0;
			words_due <= 0;
		end else begin
			// results first: a word taken at this edge cannot answer yet
			if (strobe)
				compare_word();
			if (start && !busy)
				apply_command(mode, value);
			fail_count <= fail_tally;
			words_due <= matrix_words_q.size();
		end
	end

endmodule

/* dv/transform_matrix_accumulator_core_tb.sv */
`timescale 1ns / 100ps
// transform_matrix_accumulator_core_tb: drives load, identity and transpose
// words into the core and gives the verdict from tma_product_checker.
// Depends on tma_pkg, transform_matrix_accumulator_core and tma_product_checker.
module transform_matrix_accumulator_core_tb;
	import tma_pkg::*;

	localparam int         FRAC_BITS    = 16;
	localparam logic [1:0] MODE_NOP     = 2'd3;
	localparam int         RANDOM_WORDS = 96;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               mode;
	logic signed [WORD_W-1:0] value;
	logic                     strobe;
	logic signed [WORD_W-1:0] element;
	logic [IDX_W-1:0]         row;
	logic [IDX_W-1:0]         column;
	logic                     last;
	int                       fail_count;
	int                       words_due;
	bit                       steady;
	int                       words_sent;

	transform_matrix_accumulator_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.mode   (mode),
		.value  (value),
		.strobe (strobe),
		.element(element),
		.row    (row),
		.column (column),
		.last   (last)
	);

	tma_product_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.value     (value),
		.strobe    (strobe),
		.element   (element),
		.row       (row),
		.column    (column),
		.last      (last),
		.fail_count(fail_count),
		.words_due (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic signed [WORD_W-1:0] corner_value(int n);
		case (n)
			0:  return 32'h7FFF_FFFF;
			1:  return 32'h8000_0000;
			2:  return 32'h0000_0000;
			3:  return 32'hFFFF_FFFF;
			4:  return 32'h0001_0000;
			5:  return 32'hFFFF_0000;
			6:  return 32'h0000_0001;
			7:  return 32'h8000_0001;
			8:  return 32'h5555_5555;
			9:  return 32'hAAAA_AAAA;
			10: return 32'h7FFF_0000;
			11: return 32'h0000_8000;
			12: return 32'hFFFF_8000;
			13: return 32'h0000_FFFF;
			14: return 32'h1234_5678;
			default: return 32'hEDCB_A988;
		endcase
	endfunction

	// mix of full-range words and small fixed-point values that avoid saturation
	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		endcase
	endfunction

	task automatic send_word(input logic [1:0] m, input logic signed [WORD_W-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		value <= v;
		do @(posedge clk); while (busy);
		if (m != MODE_NOP)
			words_sent++;
	endtask

	task automatic send_load_run(input int count);
		logic [1:0] cut_mode;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 11) == 0) begin
				cut_mode = 2'($urandom_range(1, 3));
				send_word(cut_mode, pick_value());
			end
			send_word(MODE_LOAD, pick_value());
		end
	endtask

	initial begin
		start <= 1'b0;
		mode <= MODE_LOAD;
		value <= '0;
		arst_n <= 1'b0;
		steady = 1'b0;
		words_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner operand, load interrupted by transpose, nop and identity
		send_word(MODE_NOP, 32'h5A5A_A5A5);
		send_word(MODE_TRANSPOSE, 32'h0);
		for (int n = 0; n < 5; n++)
			send_word(MODE_LOAD, corner_value(n));
		send_word(MODE_TRANSPOSE, 32'hFFFF_FFFF);
		send_word(MODE_NOP, 32'h0);
		for (int n = 5; n < 10; n++)
			send_word(MODE_LOAD, corner_value(n));
		send_word(MODE_IDENTITY, $urandom);
		for (int n = 10; n < CELLS; n++)
			send_word(MODE_LOAD, corner_value(n));
		send_word(MODE_TRANSPOSE, $urandom);

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: send_load_run(CELLS);
				7: send_word(MODE_TRANSPOSE, pick_value());
				8: send_word(MODE_IDENTITY, pick_value());
				default: begin
					if ($urandom_range(0, 1))
						send_word(MODE_NOP, pick_value());
					else
						send_load_run($urandom_range(1, 5));
				end
			endcase
		end
		steady = 1'b0;
		start <= 1'b0;

		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
